### hdl/mapt_pkg.sv
// Package for the MAC address text parser: types, constants and character helpers.
package mapt_pkg;

   localparam int unsigned MAC_WIDTH = 48;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [4:0] POS_MAX = 5'd31;
   localparam logic [2:0] OCTET_LAST = 3'd5;

   typedef enum logic [2:0] {
      FMT_NONE    = 3'd0,
      FMT_PAIRS   = 3'd1,
      FMT_QUADS   = 3'd2,
      FMT_HALVES  = 3'd3,
      FMT_BARE    = 3'd4,
      FMT_SHORT   = 3'd5
   } fmt_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [MAC_WIDTH-1:0] mac_addr;
   } rsp_type;

   typedef struct packed {
      logic                 body_started;
      logic [4:0]           format_alive;
      logic [4:0]           char_position;
      logic [MAC_WIDTH-1:0] nibble_acc;
      logic [7:0]           pair_delim;
      logic [7:0]           group_delim;
      logic [MAC_WIDTH-1:0] short_acc;
      logic [2:0]           short_index;
      logic [1:0]           short_count;
      logic                 in_trailing;
      fmt_type              chosen_format;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      body_started:  1'b0,
      format_alive:  5'b11111,
      char_position: 5'd0,
      nibble_acc:    '0,
      pair_delim:    8'h00,
      group_delim:   8'h00,
      short_acc:     '0,
      short_index:   3'd0,
      short_count:   2'd0,
      in_trailing:   1'b0,
      chosen_format: FMT_NONE
   };

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

### hdl/mapt_parse_core.sv
// Parser state register and the per-character recogniser update.
module mapt_parse_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  mapt_pkg::req_type  item,
   output mapt_pkg::rsp_type  result
);

   mapt_pkg::parse_state_type state_ff, state_in;

   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd16;
      if ((c >= 8'h30) && (c <= 8'h39)) v = {1'b0, c[3:0]};
      else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46)))
         v = {1'b0, c[3:0] + 4'd9};
      return v;
   endfunction

   // keep only complete notations and pick the highest ranked one
   function automatic mapt_pkg::fmt_type pick_format(input mapt_pkg::parse_state_type s,
                                                     output logic [4:0] done);
      mapt_pkg::fmt_type f;
      done[0] = s.format_alive[0] && (s.char_position == 5'd17);
      done[1] = s.format_alive[1] && (s.char_position == 5'd14);
      done[2] = s.format_alive[2] && (s.char_position == 5'd13);
      done[3] = s.format_alive[3] && (s.char_position == 5'd12);
      done[4] = s.format_alive[4] && (s.short_index == mapt_pkg::OCTET_LAST)
                && (s.short_count != 2'd0);
      priority if (done[0]) f = mapt_pkg::FMT_PAIRS;
      else if (done[1])     f = mapt_pkg::FMT_QUADS;
      else if (done[2])     f = mapt_pkg::FMT_HALVES;
      else if (done[3])     f = mapt_pkg::FMT_BARE;
      else if (done[4])     f = mapt_pkg::FMT_SHORT;
      else                  f = mapt_pkg::FMT_NONE;
      return f;
   endfunction

   function automatic mapt_pkg::parse_state_type consume(input mapt_pkg::parse_state_type s,
                                                         input logic [7:0] c);
      mapt_pkg::parse_state_type n;
      logic [4:0] hv;
      logic       hex;
      logic [4:0] p;
      n   = s;
      hv  = hex_value(c);
      hex = !hv[4];
      p   = s.char_position;

      if (p >= 5'd17) begin
         n.format_alive[0] = 1'b0;
      end else if ((p == 5'd2) || (p == 5'd5) || (p == 5'd8) || (p == 5'd11)
                   || (p == 5'd14)) begin
         if (p == 5'd2) begin
            if ((c == mapt_pkg::CHAR_COLON) || (c == mapt_pkg::CHAR_DASH)) n.pair_delim = c;
            else n.format_alive[0] = 1'b0;
         end else if (c != s.pair_delim) begin
            n.format_alive[0] = 1'b0;
         end
      end else if (!hex) begin
         n.format_alive[0] = 1'b0;
      end

      if (p >= 5'd14) begin
         n.format_alive[1] = 1'b0;
      end else if (p == 5'd4) begin
         if ((c == mapt_pkg::CHAR_COLON) || (c == mapt_pkg::CHAR_DASH)
             || (c == mapt_pkg::CHAR_DOT)) n.group_delim = c;
         else n.format_alive[1] = 1'b0;
      end else if (p == 5'd9) begin
         if (c != s.group_delim) n.format_alive[1] = 1'b0;
      end else if (!hex) begin
         n.format_alive[1] = 1'b0;
      end

      if (p >= 5'd13) begin
         n.format_alive[2] = 1'b0;
      end else if (p == 5'd6) begin
         if ((c != mapt_pkg::CHAR_COLON) && (c != mapt_pkg::CHAR_DASH))
            n.format_alive[2] = 1'b0;
      end else if (!hex) begin
         n.format_alive[2] = 1'b0;
      end

      if ((p >= 5'd12) || !hex) n.format_alive[3] = 1'b0;

      if (hex) n.nibble_acc = {s.nibble_acc[mapt_pkg::MAC_WIDTH-5:0], hv[3:0]};

      if (s.format_alive[4]) begin
         if (hex) begin
            if (s.short_count >= 2'd2) begin
               n.format_alive[4] = 1'b0;
            end else begin
               n.short_acc   = {s.short_acc[mapt_pkg::MAC_WIDTH-1:8], s.short_acc[3:0], hv[3:0]};
               n.short_count = s.short_count + 2'd1;
            end
         end else if (c == mapt_pkg::CHAR_COLON) begin
            if ((s.short_count == 2'd0) || (s.short_index >= mapt_pkg::OCTET_LAST)) begin
               n.format_alive[4] = 1'b0;
            end else begin
               n.short_acc   = {s.short_acc[mapt_pkg::MAC_WIDTH-9:0], 8'h00};
               n.short_index = s.short_index + 3'd1;
               n.short_count = 2'd0;
            end
         end else begin
            n.format_alive[4] = 1'b0;
         end
      end

      n.char_position = (p < mapt_pkg::POS_MAX) ? p + 5'd1 : mapt_pkg::POS_MAX;
      return n;
   endfunction

   always_comb begin
      mapt_pkg::parse_state_type s;
      logic [4:0]                done;
      logic                      blank;
      s      = state_ff;
      done   = '0;
      blank  = mapt_pkg::is_blank(item.ch);
      result = '0;

      if (!s.body_started) begin
         if (!blank) begin
            s.body_started = 1'b1;
            s = consume(s, item.ch);
         end
      end else if (s.in_trailing) begin
         if (!blank) begin
            s.format_alive  = '0;
            s.chosen_format = mapt_pkg::FMT_NONE;
         end
      end else if (blank) begin
         s.chosen_format = pick_format(s, done);
         s.format_alive  = done;
         s.in_trailing   = 1'b1;
      end else begin
         s = consume(s, item.ch);
      end

      if (item.last && s.body_started && !s.in_trailing) begin
         s.chosen_format = pick_format(s, done);
         s.format_alive  = done;
      end
      if (s.chosen_format != mapt_pkg::FMT_NONE) begin
         result.ok       = 1'b1;
         result.mac_addr = (s.chosen_format == mapt_pkg::FMT_SHORT) ? s.short_acc
                                                                    : s.nibble_acc;
      end

      if (item.last) state_in = mapt_pkg::STATE_RESET;
      else           state_in = s;
      if (!step)     state_in = state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mapt_pkg::STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mac_address_text_parser.sv
// Top level of the MAC address text parser: request register, parser core, result register.
// A string's result goes from the request register through the parser core into the result register.
// Throughput: one character per cycle while the result is not stalled, set by the parser state update.
// A stalled result holds the request register; further requests stall behind it.
// Synchronous reset clears the parser to its idle state and empties both registers.
module mac_address_text_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mapt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mapt_pkg::rsp_type  rsp_data
);

   logic              in_valid_ff, in_valid_in;
   mapt_pkg::req_type in_ff, in_in;
   logic              rsp_valid_ff, rsp_valid_in;
   mapt_pkg::rsp_type rsp_ff, rsp_in;
   mapt_pkg::rsp_type core_result;
   logic              advance;
   logic              step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   mapt_parse_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .result (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_in       = req_data;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (step && in_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_ff  <= in_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.ok |-> rsp_ff.mac_addr == '0)
      else $error("failed parse with nonzero address");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_ff.last))
      else $error("result raised without a final character");

   a_rsp_new : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !(in_valid_ff && in_ff.last) |=> !rsp_valid_ff)
      else $error("taken result not retired");

endmodule
